@@ rtl/core/escaped_command_packet_decoder_top_defines.svh @@
// Assertion helpers for the packet decoder. Each expects clk and rst_n in scope.
`ifndef ESCAPED_COMMAND_PACKET_DECODER_TOP_DEFINES_SVH
`define ESCAPED_COMMAND_PACKET_DECODER_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define ECPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ECPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ecpd_pkg.sv @@
`default_nettype none

package ecpd_pkg;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_HIGH = 3'd2,
    PH_LOW  = 3'd3,
    PH_ESC  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_PERIOD = 2'd1,
    ACT_LED    = 2'd2,
    ACT_DUTY   = 2'd3
  } action_t;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] ESC_LOW    = 8'h02;
  localparam logic [7:0] ESC_HIGH   = 8'h04;
  localparam logic [7:0] ESC_BOTH   = 8'h06;

  localparam logic [7:0] CMD_PERIOD = 8'h01;
  localparam logic [7:0] CMD_LED    = 8'h02;
  localparam logic [7:0] CMD_DUTY   = 8'h03;

  localparam logic [15:0] PERIOD_RESET = 16'd1999;
  localparam logic [15:0] DUTY_RESET   = 16'd1000;

endpackage

`default_nettype wire

@@ rtl/core/escaped_command_packet_decoder_top.sv @@
// Packet decoder for a byte stream: hunts for a 0xFF start byte, then takes a
// command, a data high byte, a data low byte and an escape byte that restores
// 0xFF into the low (0x02), high (0x04) or both (0x06) data bytes. Command 1
// loads the period, 2 the LED byte, 3 the duty; others change nothing. One
// result leaves per completed packet, from an output register in the cycle after
// the escape byte is taken. One byte is accepted every cycle; the only hold-up
// is in_stall, raised while a finished result sits in the output register and
// the consumer stalls it.
`default_nettype none

`include "escaped_command_packet_decoder_top_defines.svh"

module escaped_command_packet_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_period_value,
  output logic [15:0]      out_duty_value,
  output logic [7:0]       out_led_value,
  output logic [1:0]       out_applied_action,
  output logic [7:0]       out_packet_command,
  output logic [15:0]      out_packet_word
);

  ecpd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        high_r, high_nxt;
  logic [7:0]        low_r, low_nxt;
  logic [15:0]       period_r, period_nxt;
  logic [15:0]       duty_r, duty_nxt;
  logic [7:0]        led_r, led_nxt;

  logic              ovalid_r, ovalid_nxt;
  logic [15:0]       operiod_r, oduty_r, oword_r;
  logic [7:0]        oled_r, ocmd_r;
  ecpd_pkg::action_t oact_r;

  logic              in_take;
  logic              pkt_done;
  logic [7:0]        fix_hi, fix_lo;
  logic [15:0]       word;
  ecpd_pkg::action_t act;

  assign in_stall = ovalid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Escape restoration on the final byte of the packet.
  always_comb begin
    fix_hi = high_r;
    fix_lo = low_r;
    unique case (in_rx_byte)
      ecpd_pkg::ESC_LOW:  fix_lo = ecpd_pkg::START_BYTE;
      ecpd_pkg::ESC_HIGH: fix_hi = ecpd_pkg::START_BYTE;
      ecpd_pkg::ESC_BOTH: begin
        fix_lo = ecpd_pkg::START_BYTE;
        fix_hi = ecpd_pkg::START_BYTE;
      end
      default: ;
    endcase
  end

  assign word = {fix_hi, fix_lo};

  always_comb begin
    phase_nxt  = phase_r;
    cmd_nxt    = cmd_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    period_nxt = period_r;
    duty_nxt   = duty_r;
    led_nxt    = led_r;
    act        = ecpd_pkg::ACT_NONE;
    pkt_done   = 1'b0;
    if (in_take) begin
      unique case (phase_r)
        ecpd_pkg::PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          phase_nxt = ecpd_pkg::PH_HIGH;
        end
        ecpd_pkg::PH_HIGH: begin
          high_nxt  = in_rx_byte;
          phase_nxt = ecpd_pkg::PH_LOW;
        end
        ecpd_pkg::PH_LOW: begin
          low_nxt   = in_rx_byte;
          phase_nxt = ecpd_pkg::PH_ESC;
        end
        ecpd_pkg::PH_ESC: begin
          pkt_done  = 1'b1;
          phase_nxt = ecpd_pkg::PH_HUNT;
          unique case (cmd_r)
            ecpd_pkg::CMD_PERIOD: begin
              period_nxt = word;
              act        = ecpd_pkg::ACT_PERIOD;
            end
            ecpd_pkg::CMD_LED: begin
              led_nxt = fix_lo;
              act     = ecpd_pkg::ACT_LED;
            end
            ecpd_pkg::CMD_DUTY: begin
              duty_nxt = word;
              act      = ecpd_pkg::ACT_DUTY;
            end
            default: act = ecpd_pkg::ACT_NONE;
          endcase
        end
        // Hunting, and any phase code that cannot be reached.
        default: begin
          phase_nxt = (in_rx_byte == ecpd_pkg::START_BYTE) ? ecpd_pkg::PH_CMD
                                                            : ecpd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Load a new result, or drop the old one once it has been taken.
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (pkt_done) begin
      ovalid_nxt = 1'b1;
    end else if (!out_stall) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ecpd_pkg::PH_HUNT;
      cmd_r    <= '0;
      high_r   <= '0;
      low_r    <= '0;
      period_r <= ecpd_pkg::PERIOD_RESET;
      duty_r   <= ecpd_pkg::DUTY_RESET;
      led_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cmd_r    <= cmd_nxt;
      high_r   <= high_nxt;
      low_r    <= low_nxt;
      period_r <= period_nxt;
      duty_r   <= duty_nxt;
      led_r    <= led_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      operiod_r <= period_nxt;
      oduty_r   <= duty_nxt;
      oled_r    <= led_nxt;
      oact_r    <= act;
      ocmd_r    <= cmd_r;
      oword_r   <= word;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_period_value   = operiod_r;
  assign out_duty_value     = oduty_r;
  assign out_led_value      = oled_r;
  assign out_applied_action = oact_r;
  assign out_packet_command = ocmd_r;
  assign out_packet_word    = oword_r;

  `ECPD_ASSERT_NEXT(a_esc_emits, in_take && phase_r == ecpd_pkg::PH_ESC,
    out_valid && phase_r == ecpd_pkg::PH_HUNT, "escape byte did not complete packet")
  `ECPD_ASSERT_SAME(a_period_word, out_valid && oact_r == ecpd_pkg::ACT_PERIOD,
    out_period_value == out_packet_word, "period result differs from word")
  `ECPD_ASSERT_SAME(a_led_word, out_valid && oact_r == ecpd_pkg::ACT_LED,
    out_led_value == out_packet_word[7:0], "LED result differs from low byte")
  `ECPD_ASSERT_NEXT(a_hunt_drop,
    in_take && phase_r == ecpd_pkg::PH_HUNT && in_rx_byte != ecpd_pkg::START_BYTE,
    phase_r == ecpd_pkg::PH_HUNT, "non-start byte left hunting")

endmodule

`default_nettype wire
